[rtl/brl_pkg.sv]
// ============================================================================
// brl_pkg - shared types and constants of the line rasterizer
// Coordinate widths, frame-buffer address layout and the command and pixel
// records that travel between the front end, the queue and the back end.
// ============================================================================
package brl_pkg;

    localparam int COORD_BITS = 9;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int COLOR_BITS = 16;
    localparam int ADDR_BITS  = 32;
    localparam int ROW_SHIFT  = 10;
    localparam int COL_SHIFT  = 1;

    // Packed stream words, rounded up to whole bytes.
    localparam int IN_FIELDS_W  = 4 * COORD_BITS + COLOR_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [ERR_BITS-1:0]   err_t;
    typedef logic [COLOR_BITS-1:0] color_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    // One classified word. The line fields are meaningful on OP_START only.
    typedef struct packed {
        opcode_t op;
        logic    steep;
        logic    step_down;
        coord_t  major_pos;
        coord_t  major_end;
        coord_t  minor_pos;
        coord_t  major_delta;
        coord_t  minor_delta;
        err_t    error_init;
        color_t  color;
    } line_cmd_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        addr_t  addr;
        color_t color;
        logic   last;
    } pixel_t;

endpackage

[rtl/brl_front.sv]
// ============================================================================
// brl_front - word intake and line setup
// Accepts input words, classifies them and, for a start word, works out the
// axis swap, endpoint order, deltas and initial error before queueing.
// ============================================================================
module brl_front
    import brl_pkg::*;
(
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  q_full,
    output logic                  q_push,
    output line_cmd_t             q_cmd
);

    function automatic coord_t span(input coord_t a, input coord_t b);
        span = (a > b) ? (a - b) : (b - a);
    endfunction

    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t maj0;
    coord_t min0;
    coord_t maj1;
    coord_t min1;
    coord_t lo_maj;
    coord_t lo_min;
    coord_t hi_maj;
    coord_t hi_min;
    coord_t maj_delta;
    logic   steep;

    assign ax = s_axis_tdata[COORD_BITS-1:0];
    assign ay = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign bx = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign by = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        steep = span(ay, by) > span(ax, bx);
        maj0  = steep ? ay : ax;
        min0  = steep ? ax : ay;
        maj1  = steep ? by : bx;
        min1  = steep ? bx : by;
        // Order the endpoints so that the major coordinate rises.
        if (maj0 > maj1)
        begin
            lo_maj = maj1;
            lo_min = min1;
            hi_maj = maj0;
            hi_min = min0;
        end
        else
        begin
            lo_maj = maj0;
            lo_min = min0;
            hi_maj = maj1;
            hi_min = min1;
        end
        maj_delta = hi_maj - lo_maj;

        q_cmd.op          = opcode_t'(s_axis_tuser);
        q_cmd.steep       = steep;
        q_cmd.step_down   = !(lo_min < hi_min);
        q_cmd.major_pos   = lo_maj;
        q_cmd.major_end   = hi_maj;
        q_cmd.minor_pos   = lo_min;
        q_cmd.major_delta = maj_delta;
        q_cmd.minor_delta = span(lo_min, hi_min);
        // Error starts at minus half the major delta, the half rounded down.
        q_cmd.error_init  = err_t'(0) - err_t'(maj_delta >> 1);
        q_cmd.color       = s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
    end

endmodule

[rtl/brl_queue.sv]
// ============================================================================
// brl_queue - short command queue
// A small first-in first-out store of classified words between the front
// end and the back end, so that either side may stall without the other.
// ============================================================================
module brl_queue
    import brl_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  line_cmd_t push_cmd,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output line_cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    line_cmd_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/brl_back.sv]
// ============================================================================
// brl_back - line stepper and pixel output stage
// Holds the active line, pops one queued word per cycle (steps wait on a
// stall), advances Bresenham error, registers pixel and frame-buffer address.
// ============================================================================
module brl_back
    import brl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  addr_t     cfg_wdata,
    input  logic      head_valid,
    input  line_cmd_t head_cmd,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output pixel_t    out_pixel
);

    addr_t  frame_base_reg;
    logic   active_reg;
    logic   active_next;
    logic   steep_reg;
    logic   step_down_reg;
    coord_t major_pos_reg;
    coord_t major_pos_next;
    coord_t major_end_reg;
    coord_t minor_pos_reg;
    coord_t minor_pos_next;
    coord_t major_delta_reg;
    coord_t minor_delta_reg;
    err_t   err_reg;
    err_t   err_next;
    color_t color_reg;
    logic   valid_reg;
    logic   valid_next;
    pixel_t pixel_reg;
    pixel_t pixel_next;

    logic   load_ok;
    logic   is_start;
    logic   emit;
    logic   last;
    err_t   err_sum;
    coord_t px;
    coord_t py;

    assign load_ok  = !valid_reg || out_ready;
    assign is_start = head_valid && (head_cmd.op == OP_START);
    // A step with no active line is dropped without waiting for the output.
    assign emit     = head_valid && (head_cmd.op == OP_STEP) && active_reg && load_ok;
    assign pop      = is_start
                   || (head_valid && (head_cmd.op == OP_STEP) && (!active_reg || load_ok));

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

    always_comb
    begin
        px      = steep_reg ? minor_pos_reg : major_pos_reg;
        py      = steep_reg ? major_pos_reg : minor_pos_reg;
        last    = (major_pos_reg == major_end_reg);
        err_sum = err_reg + err_t'(minor_delta_reg);

        pixel_next.x     = px;
        pixel_next.y     = py;
        pixel_next.addr  = frame_base_reg + (addr_t'(py) << ROW_SHIFT)
                         + (addr_t'(px) << COL_SHIFT);
        pixel_next.color = color_reg;
        pixel_next.last  = last;

        active_next    = active_reg;
        major_pos_next = major_pos_reg;
        minor_pos_next = minor_pos_reg;
        err_next       = err_reg;
        if (emit)
        begin
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = err_sum;
                if ($signed(err_sum) > 0)
                begin
                    minor_pos_next = step_down_reg ? minor_pos_reg - 1'b1
                                                   : minor_pos_reg + 1'b1;
                    err_next       = err_sum - err_t'(major_delta_reg);
                end
                major_pos_next = major_pos_reg + 1'b1;
            end
        end

        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= '0;
            active_reg     <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_base_reg <= cfg_wdata;
            end
            active_reg <= is_start ? 1'b1 : active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_start)
        begin
            steep_reg       <= head_cmd.steep;
            step_down_reg   <= head_cmd.step_down;
            major_pos_reg   <= head_cmd.major_pos;
            major_end_reg   <= head_cmd.major_end;
            minor_pos_reg   <= head_cmd.minor_pos;
            major_delta_reg <= head_cmd.major_delta;
            minor_delta_reg <= head_cmd.minor_delta;
            err_reg         <= head_cmd.error_init;
            color_reg       <= head_cmd.color;
        end
        else
        begin
            major_pos_reg <= major_pos_next;
            minor_pos_reg <= minor_pos_next;
            err_reg       <= err_next;
        end
        if (emit)
        begin
            pixel_reg <= pixel_next;
        end
    end

endmodule

[rtl/bresenham_line_rasterizer.sv]
// ============================================================================
// bresenham_line_rasterizer - integer line rasterizer with address output
//
//   Channel  Direction  Handshake          Contents
//   s_axis   in         tvalid / tready    start or step word, opcode on tuser
//   m_axis   out        tvalid / tready    one pixel word, last pixel on tlast
//   cfg      in         cfg_we             frame base byte address
//
// The front end classifies each word and sets up a start word in the cycle
// it is accepted, and the back end retires one queued word per cycle while
// no step waits on a stalled m_axis. An accepted step word is written into
// the queue; it is popped at the edge that registers its pixel and sets
// m_axis_tvalid. The rate is set by the error update loop in the back end.
// Reset clears the queue, the output register and the active-line flag, and
// sets the frame base to zero. A stall on m_axis holds the pixel register;
// the queue absorbs QUEUE_DEPTH words before s_axis_tready falls.
// ============================================================================
module bresenham_line_rasterizer
    import brl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [ADDR_BITS-1:0]   cfg_wdata,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // From bit 0 up: start_x, start_y, end_x, end_y, pen_color, zero padding.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Opcode: zero starts a line, one steps a pixel.
    input  logic                   s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // From bit 0 up: pixel_x, pixel_y, pixel_addr, pixel_color, zero padding.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Set on the final pixel of the line.
    output logic                   m_axis_tlast
);

    // Front end to queue, and queue to back end.
    logic      q_full;
    logic      q_push;
    line_cmd_t q_cmd;
    logic      q_pop;
    logic      q_head_valid;
    line_cmd_t q_head_cmd;
    pixel_t    out_pixel;

    brl_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    brl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    brl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_pixel  (out_pixel)
    );

    // Pack the pixel word; the top bits are padding to a whole byte.
    assign m_axis_tdata = OUT_TDATA_W'({out_pixel.color, out_pixel.addr,
                                        out_pixel.y, out_pixel.x});
    assign m_axis_tlast = out_pixel.last;

endmodule

[sim/tb_bresenham_line_rasterizer.sv]
// ============================================================================
// tb_bresenham_line_rasterizer - self-checking testbench of the line rasterizer
// Start and step words are driven into s_axis in random bursts. A predictor
// traces each accepted word and queues the pixel it should produce. Each
// pixel word taken from m_axis is checked field by field against that queue.
// ============================================================================
module tb_bresenham_line_rasterizer;

    timeunit 1ns;
    timeprecision 1ps;

    import brl_pkg::*;

    // Quiet cycles (no word accepted on either side) before the run is declared hung.
    localparam int     QUIET_LIMIT   = 2000;
    // Cycles left after the last pixel so that queued start and idle step words settle.
    localparam int     SETTLE_CYCLES = 12;
    localparam coord_t COORD_MAX     = '1;

    // One input word as the sender sees it, before packing onto s_axis.
    typedef struct packed {
        opcode_t op;
        coord_t  sx;
        coord_t  sy;
        coord_t  ex;
        coord_t  ey;
        color_t  color;
    } raster_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [ADDR_BITS-1:0]   cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    bresenham_line_rasterizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Line tracer. It holds its own copy of the frame base and of the line
    // being drawn, and is advanced once for every word accepted on s_axis.
    // ------------------------------------------------------------------------
    addr_t                     frame_base = '0;
    logic                      ln_active = 1'b0;
    logic                      ln_steep = 1'b0;
    coord_t                    maj_pos = '0;
    coord_t                    maj_end = '0;
    coord_t                    min_pos = '0;
    logic                      min_down = 1'b0;
    coord_t                    maj_delta = '0;
    coord_t                    min_delta = '0;
    logic signed [ERR_BITS-1:0] err_acc = '0;
    color_t                    pen = '0;

    // Pixels still owed by the block, oldest first.
    pixel_t pixel_q[$];

    int fail_count     = 0;
    int lines_started  = 0;
    int steep_lines    = 0;
    int lines_cut      = 0;
    int idle_steps     = 0;
    int pixels_checked = 0;

    function automatic coord_t coord_dist(input coord_t a, input coord_t b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic trace_word(input raster_cmd_t w);
        coord_t m0, n0, m1, n1, t;
        pixel_t px;
        if (w.op == OP_START)
        begin
            // A new start simply replaces whatever line was in progress.
            if (ln_active)
                lines_cut++;
            lines_started++;
            ln_steep = coord_dist(w.sy, w.ey) > coord_dist(w.sx, w.ex);
            if (ln_steep)
            begin
                m0 = w.sy; n0 = w.sx; m1 = w.ey; n1 = w.ex;
                steep_lines++;
            end
            else
            begin
                m0 = w.sx; n0 = w.sy; m1 = w.ex; n1 = w.ey;
            end
            // Walk the major axis upwards whichever endpoint came first.
            if (m0 > m1)
            begin
                t = m0; m0 = m1; m1 = t;
                t = n0; n0 = n1; n1 = t;
            end
            maj_pos   = m0;
            maj_end   = m1;
            min_pos   = n0;
            maj_delta = m1 - m0;
            min_delta = coord_dist(n0, n1);
            min_down  = !(n0 < n1);
            err_acc   = -$signed({2'b00, maj_delta >> 1});
            pen       = w.color;
            ln_active = 1'b1;
        end
        else if (!ln_active)
        begin
            idle_steps++;
        end
        else
        begin
            px.x     = ln_steep ? min_pos : maj_pos;
            px.y     = ln_steep ? maj_pos : min_pos;
            px.addr  = frame_base + (addr_t'(px.y) << ROW_SHIFT) + (addr_t'(px.x) << COL_SHIFT);
            px.color = pen;
            px.last  = (maj_pos == maj_end);
            pixel_q.push_back(px);
            if (px.last)
            begin
                ln_active = 1'b0;
            end
            else
            begin
                err_acc = err_acc + $signed({2'b00, min_delta});
                if (err_acc > 0)
                begin
                    min_pos = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
                    err_acc = err_acc - $signed({2'b00, maj_delta});
                end
                maj_pos = maj_pos + 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender. Words go out in bursts of random length; between bursts the
    // valid line drops for a random gap bounded by gap_max; a gap of zero keeps
    // valid high across bursts, so a phase with gap_max at zero has no idling.
    // After a word is accepted, valid is left high: the caller either sends
    // the next word in the same time step or lowers valid via drain_pixels.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_max    = 0;

    task automatic send_word(input raster_cmd_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.op;
        s_axis_tdata  <= IN_TDATA_W'({w.color, w.ey, w.ex, w.sy, w.sx});
        do
            @(posedge clk);
        while (!s_axis_tready);
        trace_word(w);
    endtask

    task automatic start_line(input int sx, input int sy, input int ex, input int ey,
                              input int color);
        raster_cmd_t w;
        w.op    = OP_START;
        w.sx    = coord_t'(sx);
        w.sy    = coord_t'(sy);
        w.ex    = coord_t'(ex);
        w.ey    = coord_t'(ey);
        w.color = color_t'(color);
        send_word(w);
    endtask

    // Step words carry random rubbish in the endpoint fields, which must be ignored.
    task automatic step_line(input int count);
        raster_cmd_t w;
        repeat (count)
        begin
            w.op    = OP_STEP;
            w.sx    = coord_t'($urandom);
            w.sy    = coord_t'($urandom);
            w.ex    = coord_t'($urandom);
            w.ey    = coord_t'($urandom);
            w.color = color_t'($urandom);
            send_word(w);
        end
    endtask

    // Lowers valid and holds the sender off until every owed pixel is back.
    // It always waits on a clock edge first, so valid is never lowered and
    // raised again in the same time step.
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
    endtask

    // The frame base is only changed once the block is idle: all pixels
    // returned and any trailing start or idle step words given time to clear.
    task automatic set_frame_base(input addr_t base);
        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_we     <= 1'b0;
        frame_base = base;
    endtask

    // ------------------------------------------------------------------------
    // Receiver. tready follows alternating runs of ready and stalled cycles
    // whose lengths scale with stall_max; at zero it stays high.
    // ------------------------------------------------------------------------
    int stall_max = 0;
    int stall_run = 0;

    always @(posedge clk)
    begin
        if (stall_max == 0)
        begin
            m_axis_tready <= 1'b1;
            stall_run = 0;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
        end
        else
        begin
            m_axis_tready <= !m_axis_tready;
            stall_run = m_axis_tready ? $urandom_range(0, stall_max - 1)
                                      : $urandom_range(0, 3 * stall_max);
        end
    end

    // ------------------------------------------------------------------------
    // Pixel checker. Every word accepted on m_axis is unpacked and compared
    // with the oldest owed pixel.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : pixel_check
        pixel_t got;
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            {got.color, got.addr, got.y, got.x} = m_axis_tdata[OUT_FIELDS_W-1:0];
            got.last = m_axis_tlast;
            if (pixel_q.size() == 0)
            begin
                $error("pixel word with none owed: x=%0d y=%0d addr=%h",
                       got.x, got.y, got.addr);
                fail_count++;
            end
            else
            begin
                want = pixel_q.pop_front();
                pixels_checked++;
                if (got.x !== want.x)
                begin
                    $error("pixel_x: expected %0d, got %0d", want.x, got.x);
                    fail_count++;
                end
                if (got.y !== want.y)
                begin
                    $error("pixel_y: expected %0d, got %0d", want.y, got.y);
                    fail_count++;
                end
                if (got.addr !== want.addr)
                begin
                    $error("pixel_addr: expected %h, got %h", want.addr, got.addr);
                    fail_count++;
                end
                if (got.color !== want.color)
                begin
                    $error("pixel_color: expected %h, got %h", want.color, got.color);
                    fail_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_pixel: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a hung handshake or a lost pixel shows up as a long stretch
    // in which no word moves on either side.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no word accepted for %0d cycles", QUIET_LIMIT);
            $display("** bresenham_line_rasterizer: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Steps with no line armed, and a line of a single point at the all-ones corner
    // of the coordinate range. The all-ones base makes the address wrap.
    task automatic test_idle_and_points();
        set_frame_base(32'hFFFF_FFFF);
        gap_max   = 2;
        stall_max = 3;
        step_line(1);
        start_line(int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX),
                   16'hFFFF);
        step_line(2);
    endtask

    // A flat line from the origin, a steep line entered from its upper end
    // (so the endpoints are swapped), and a falling diagonal.
    task automatic test_octants();
        start_line(0, 0, 3, 0, 16'h0001);
        step_line(4);
        start_line(2, int'(COORD_MAX), 0, int'(COORD_MAX) - 3, 16'hA5A5);
        step_line(4);
        start_line(0, 3, 3, 0, 16'h5A5A);
        step_line(4);
    endtask

    // A start that lands while a long line is still being drawn drops it,
    // and the vertical replacement must stay straight.
    task automatic test_restart();
        start_line(0, 0, 500, 1, 16'h1234);
        step_line(1);
        start_line(5, 0, 5, 2, 16'h8000);
        step_line(3);
    endtask

    // ------------------------------------------------------------------------
    // Random lines. Most are short and fully drawn, a few run past their end
    // into ignored steps or are cut short, long lines are mostly interrupted
    // by the next start, and some starts are overwritten at once.
    // ------------------------------------------------------------------------
    function automatic coord_t near_coord(input coord_t c);
        int v;
        v = int'(c) + int'($urandom_range(0, 24)) - 12;
        if (v < 0)
            v = 0;
        if (v > int'(COORD_MAX))
            v = int'(COORD_MAX);
        return coord_t'(v);
    endfunction

    task automatic test_random_lines(input int n_words, input addr_t base,
                                     input int gaps, input int stalls);
        int     done;
        int     kind;
        int     len;
        int     steps;
        int     dx;
        int     dy;
        logic   held;
        coord_t ax, ay, bx, by;
        set_frame_base(base);
        gap_max   = gaps;
        stall_max = stalls;
        done      = 0;
        held      = 1'b0;
        while (done < n_words)
        begin
            // Now and then the sender waits until every owed pixel has come back.
            if ((!held && done > 20) || $urandom_range(0, 15) == 0)
            begin
                drain_pixels();
                held = 1'b1;
            end
            kind = $urandom_range(0, 15);
            ax = coord_t'($urandom);
            ay = coord_t'($urandom);
            if ($urandom_range(0, 5) == 0)
                ax = $urandom_range(0, 1) ? COORD_MAX : '0;
            if ($urandom_range(0, 5) == 0)
                ay = $urandom_range(0, 1) ? COORD_MAX : '0;
            if (kind < 11)
            begin
                bx = near_coord(ax);
                by = near_coord(ay);
            end
            else if (kind == 11)
            begin
                bx = $urandom_range(0, 1) ? ax : near_coord(ax);
                by = (bx == ax) ? near_coord(ay) : ay;
            end
            else
            begin
                bx = coord_t'($urandom);
                by = coord_t'($urandom);
            end
            dx  = int'(coord_dist(ax, bx));
            dy  = int'(coord_dist(ay, by));
            len = ((dx > dy) ? dx : dy) + 1;
            if (kind < 12)
            begin
                case ($urandom_range(0, 7))
                    0:       steps = $urandom_range(0, len - 1);
                    1:       steps = len + $urandom_range(1, 2);
                    default: steps = len;
                endcase
            end
            else if (kind < 14)
            begin
                steps = $urandom_range(1, 24);
            end
            else
            begin
                steps = 0;
            end
            start_line(int'(ax), int'(ay), int'(bx), int'(by), $urandom);
            step_line(steps);
            done += 1 + ((steps < len) ? steps : len);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_points();
        test_octants();
        test_restart();
        test_random_lines(110, 32'h0000_0000, 0, 0);
        test_random_lines(150, addr_t'($urandom), 8, 16);
        test_random_lines(120, addr_t'($urandom) | 32'hFFF0_0000, 3, 4);

        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d lines (%0d steep, %0d dropped by a new start), %0d pixels checked,",
                 lines_started, steep_lines, lines_cut, pixels_checked);
        $display("%0d steps with no line armed, frame bases from zero to all ones, with and without idling.",
                 idle_steps);
        if (fail_count == 0)
        begin
            $display("** bresenham_line_rasterizer: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("** bresenham_line_rasterizer: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/brl_pkg.sv
rtl/brl_front.sv
rtl/brl_queue.sv
rtl/brl_back.sv
rtl/bresenham_line_rasterizer.sv
sim/tb_bresenham_line_rasterizer.sv
